// ----- hw/rtl/bss_pkg.sv -----
// Shared types and constants for the bounded stack with exchange sort.
// Holds the input and result item structs, command and status codes, and reset values.
// No dependencies.
package bss_pkg;

  localparam int unsigned DepthDefault = 32;
  localparam int unsigned WordWidth    = 32;

  localparam logic [5:0] CapacityLimitReset = 6'd10;

  // Command kinds.
  localparam logic [1:0] KindPush    = 2'd0;
  localparam logic [1:0] KindPop     = 2'd1;
  localparam logic [1:0] KindSortMin = 2'd2;
  localparam logic [1:0] KindSortMax = 2'd3;

  // Result status codes.
  localparam logic [1:0] StatusDone  = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  typedef struct packed {
    logic [1:0]                  kind;
    logic signed [WordWidth-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                  status;
    logic signed [WordWidth-1:0] pop_value;
    logic [5:0]                  entry_count;
  } out_item_t;

  // Top level to core control.
  typedef struct packed {
    logic req_valid;
    logic res_ready;
  } core_ctrl_t;

  // Core to top level status.
  typedef struct packed {
    logic busy;
    logic res_valid;
  } core_stat_t;

endpackage

// ----- hw/rtl/bounded_stack_with_sort.sv -----
// Bounded stack of signed 32-bit words with two in-place exchange sorts. One command is taken
// at a time and gives one result beat. A push, a pop on an empty stack and a sort of fewer
// than two entries give their result straight from the idle state; any other pop first reads
// the stack memory and gives its result from the pop state. A sort runs its passes through the
// single memory read port, which visits every pair once, and each pass also loads its held word
// and writes it back. A result waits in an output register; a new command is taken only
// while that register is empty or its beat leaves at the same edge, so a stalled result holds
// off the next command. The capacity limit, written through its own port, saturates at the
// memory depth; the user must write it only while the block is idle, which it does not enforce.
// Depends on bss_pkg and bss_core.
module bounded_stack_with_sort
  import bss_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_item_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_item_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [5:0] cfg_data_i
);

  logic [5:0] limit_q;
  logic       out_valid_q;
  out_item_t  out_item_q;
  logic       slot_free;
  core_ctrl_t ctrl;
  core_stat_t stat;
  out_item_t  res;

  assign slot_free      = !out_valid_q || !out_stall_i;
  assign in_stall_o     = stat.busy || !slot_free;
  assign ctrl.req_valid = in_valid_i && !in_stall_o;
  assign ctrl.res_ready = slot_free;
  assign cfg_ready_o    = 1'b1;

  bss_core #(
    .DEPTH(DEPTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .req_i  (in_item_i),
    .limit_i(limit_q),
    .stat_o (stat),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= CapacityLimitReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
      if (stat.res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- hw/rtl/bss_core.sv -----
// Stack core: the word memory, the entry count and the command sequencer.
// Runs push, pop and both exchange sorts through one synchronous memory.
// Depends on bss_pkg.
module bss_core
  import bss_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  core_ctrl_t ctrl_i,
  input  in_item_t   req_i,
  input  logic [5:0] limit_i,
  output core_stat_t stat_o,
  output out_item_t  res_o
);

  localparam int unsigned AddrWidth = $clog2(DEPTH);
  localparam logic [5:0] DepthCap = 6'((DEPTH > 63) ? 63 : DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_POP   = 3'd1;
  localparam logic [2:0] ST_FIRST = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_WRI   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [AddrWidth-1:0] i_q, i_d, j_q, j_d;
  logic signed [WordWidth-1:0] held_q, held_d;
  logic min_top_q, min_top_d;

  logic signed [WordWidth-1:0] mem_q [DEPTH];
  logic signed [WordWidth-1:0] rdata_q;
  logic                        we, re;
  logic [AddrWidth-1:0]        waddr, raddr;
  logic signed [WordWidth-1:0] wdata;

  logic [5:0] eff_limit;
  logic       swap;
  logic       last_j, last_i;

  assign eff_limit = (limit_i > DepthCap) ? DepthCap : limit_i;
  assign swap      = min_top_q ? (held_q < rdata_q) : (held_q > rdata_q);
  assign last_j    = (j_q == AddrWidth'(cnt_q - 6'd1));
  assign last_i    = (i_q == AddrWidth'(cnt_q - 6'd2));

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    i_d       = i_q;
    j_d       = j_q;
    held_d    = held_q;
    min_top_d = min_top_q;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = j_q;
    raddr     = j_q;
    wdata     = held_q;
    stat_o.busy       = (state_q != ST_IDLE);
    stat_o.res_valid  = 1'b0;
    res_o.status      = StatusDone;
    res_o.pop_value   = '0;
    res_o.entry_count = cnt_q;

    unique case (state_q)
      ST_IDLE: begin
        if (ctrl_i.req_valid) begin
          unique case (req_i.kind) inside
            KindPush: begin
              stat_o.res_valid = 1'b1;
              if (cnt_q >= eff_limit) begin
                res_o.status = StatusFull;
              end else begin
                we    = 1'b1;
                waddr = AddrWidth'(cnt_q);
                wdata = req_i.push_value;
                cnt_d = cnt_q + 6'd1;
                res_o.entry_count = cnt_q + 6'd1;
              end
            end
            KindPop: begin
              if (cnt_q == 6'd0) begin
                stat_o.res_valid = 1'b1;
                res_o.status     = StatusEmpty;
              end else begin
                re      = 1'b1;
                raddr   = AddrWidth'(cnt_q - 6'd1);
                cnt_d   = cnt_q - 6'd1;
                state_d = ST_POP;
              end
            end
            KindSortMin, KindSortMax: begin
              if (cnt_q < 6'd2) begin
                stat_o.res_valid = 1'b1;
              end else begin
                min_top_d = (req_i.kind == KindSortMin);
                i_d       = '0;
                re        = 1'b1;
                raddr     = '0;
                state_d   = ST_FIRST;
              end
            end
          endcase
        end
      end
      ST_POP: begin
        if (ctrl_i.res_ready) begin
          stat_o.res_valid = 1'b1;
          res_o.pop_value  = rdata_q;
          state_d          = ST_IDLE;
        end
      end
      ST_FIRST: begin
        // held_q holds the word bound for position i until the pass ends.
        held_d  = rdata_q;
        j_d     = i_q + AddrWidth'(1);
        re      = 1'b1;
        raddr   = i_q + AddrWidth'(1);
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (swap) begin
          we     = 1'b1;
          waddr  = j_q;
          wdata  = held_q;
          held_d = rdata_q;
        end
        if (last_j) begin
          state_d = ST_WRI;
        end else begin
          j_d   = j_q + AddrWidth'(1);
          re    = 1'b1;
          raddr = j_q + AddrWidth'(1);
        end
      end
      ST_WRI: begin
        we    = 1'b1;
        waddr = i_q;
        wdata = held_q;
        if (last_i) begin
          state_d = ST_FIN;
        end else begin
          i_d     = i_q + AddrWidth'(1);
          re      = 1'b1;
          raddr   = i_q + AddrWidth'(1);
          state_d = ST_FIRST;
        end
      end
      ST_FIN: begin
        if (ctrl_i.res_ready) begin
          stat_o.res_valid = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      i_q       <= '0;
      j_q       <= '0;
      min_top_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      i_q       <= i_d;
      j_q       <= j_d;
      min_top_q <= min_top_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_q <= held_d;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCap)
    else $error("entry count beyond memory depth");

  a_no_same_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> (waddr != raddr))
    else $error("memory read and write hit the same entry in one cycle");

  a_res_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.res_valid |-> ctrl_i.res_ready)
    else $error("result produced while the output register is occupied");

  a_scan_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (j_q > i_q))
    else $error("sort scan index not above the held position");

  a_cnt_stable_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |=> $stable(cnt_q))
    else $error("entry count changed while a command was in progress");
`endif

endmodule
